[sv/cbpq_pkg.sv]
// ----------------------------------------------------------------------------
// cbpq_pkg: shared types and constants of the circular bucket priority queue
// Field widths, command and status codes, and the sequencer state encoding.
// ----------------------------------------------------------------------------
package cbpq_pkg;

    localparam int CMD_W        = 3;
    localparam int KEY_W        = 32;
    localparam int PAY_W        = 32;
    localparam int HANDLE_W     = 10;
    localparam int STAT_W       = 3;
    localparam int COUNT_W      = 11;
    localparam int DEF_BUCKETS  = 256;
    localparam int DEF_CAPACITY = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_PEEK    = 3'd1,
        CMD_DEL_MIN = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_REKEY   = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_KEY_RANGE = 3'd2,
        ST_NO_FREE   = 3'd3,
        ST_BAD_HANDLE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_LINK_RD,
        S_LINK_WR,
        S_LINK_FIX,
        S_HEAD,
        S_INFO,
        S_LIVE,
        S_UNL_RD,
        S_UNL_WR,
        S_RESCAN,
        S_RESP
    } state_t;

endpackage

[sv/cbpq_ram.sv]
// ----------------------------------------------------------------------------
// cbpq_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cbpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/circular_bucket_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// circular_bucket_priority_queue_unit: monotone circular bucket priority queue
// Items live in circular buckets keyed relative to the current minimum key.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on s_* (insert, peek at the minimum, del_min,
// remove by handle, rekey, clear) and exactly one result beat leaves on m_*
// (status, handle, payload of the minimum item, item count after the command).
// Each command is run by a small sequencer over block RAMs with registered
// reads; s_ready is high only while the sequencer is idle.
// Clear, the unused codes and commands rejected at decode go straight to the
// result; a remove or rekey of a retired handle and a rekey out of range stop
// after the liveness read. Remove, del_min and rekey end in a forward scan
// that steps over each empty bucket (up to BUCKETS - 1) to the new minimum;
// the scan sets the worst case. The next command is accepted only once the
// result of the previous one has been loaded.
// Reset (aresetn low at a clock edge) empties the queue at once: bucket
// occupancy is kept in flip-flops and handle liveness is qualified by the
// count of handles issued since the last clear, so no clearing pass runs.
// A result that the receiver stalls stays in the output register; the next
// command is accepted meanwhile and waits in its final state until the output
// register frees.
// ----------------------------------------------------------------------------
module circular_bucket_priority_queue_unit #(
    parameter int BUCKETS  = cbpq_pkg::DEF_BUCKETS,
    parameter int CAPACITY = cbpq_pkg::DEF_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cbpq_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [cbpq_pkg::KEY_W-1:0] s_key,
    input  logic [cbpq_pkg::PAY_W-1:0]    s_payload,
    input  logic [cbpq_pkg::HANDLE_W-1:0] s_handle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cbpq_pkg::STAT_W-1:0]   m_status,
    output logic [cbpq_pkg::HANDLE_W-1:0] m_item_handle,
    output logic [cbpq_pkg::PAY_W-1:0]    m_item_payload,
    output logic [cbpq_pkg::COUNT_W-1:0]  m_item_count
);

    import cbpq_pkg::*;

    localparam int HW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int BW = $clog2(BUCKETS);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [PAY_W-1:0]    pay_reg;
    logic [HANDLE_W-1:0] hin_reg;
    logic [HW-1:0]       h_reg;
    logic [BW-1:0]       nb_reg;
    logic [LW-1:0]       n_reg;

    logic [BUCKETS-1:0]  bnz_reg;
    logic [LW-1:0]       free_top_reg;
    logic [LW-1:0]       fresh_next_reg;
    logic [BW-1:0]       min_bucket_reg;
    logic [KEY_W-1:0]    min_value_reg;
    logic [LW-1:0]       live_count_reg;

    status_t             res_status_reg;
    logic [HW-1:0]       res_handle_reg;
    logic [PAY_W-1:0]    res_pay_reg;
    logic                m_valid_reg;
    logic [STAT_W-1:0]   m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [PAY_W-1:0]    m_pay_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    // RAM ports
    logic          head_we, next_we, prev_we, bkt_we, info_we, live_we, free_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [HW-1:0] next_waddr, prev_waddr, bkt_waddr, info_waddr, live_waddr;
    logic [HW-1:0] free_waddr, free_raddr, info_raddr, live_raddr;
    logic [LW-1:0] head_wdata, next_wdata, prev_wdata;
    logic [LW-1:0] head_rdata, next_rdata, prev_rdata;
    logic [BW-1:0] bkt_wdata, bkt_rdata;
    logic [PAY_W-1:0] info_wdata, info_rdata;
    logic          live_wdata, live_rdata;
    logic [HW-1:0] free_wdata, free_rdata;

    // Datapath helpers
    logic [KEY_W:0] key_diff;
    logic           in_range;
    logic [BW:0]    bkt_sum;
    logic [BW-1:0]  new_bkt;
    logic           handle_known;
    logic [LW-1:0]  bkt_first;
    logic [LW-1:0]  free_top_dec;
    logic           is_del;
    logic           out_free;

    assign key_diff = {key_reg[KEY_W-1], key_reg} - {min_value_reg[KEY_W-1], min_value_reg};
    assign in_range = !key_diff[KEY_W] && (key_diff < (KEY_W+1)'(BUCKETS));
    assign bkt_sum  = (BW+1)'(min_bucket_reg) + (BW+1)'(key_diff[BW-1:0]);
    assign new_bkt  = (bkt_sum >= (BW+1)'(BUCKETS)) ? BW'(bkt_sum - (BW+1)'(BUCKETS))
                                                    : bkt_sum[BW-1:0];
    // A handle never issued since the last clear cannot be live.
    assign handle_known = 32'(hin_reg) < 32'(fresh_next_reg);
    assign bkt_first    = bnz_reg[nb_reg] ? head_rdata : NIL;
    assign free_top_dec = free_top_reg - LW'(1);
    assign is_del       = (cmd_reg == CMD_DEL_MIN) || (cmd_reg == CMD_REMOVE);
    assign out_free     = !m_valid_reg || m_ready;

    assign head_raddr = (state_reg == S_LINK_RD) ? nb_reg : min_bucket_reg;
    assign info_raddr = head_rdata[HW-1:0];
    assign live_raddr = HW'(hin_reg);
    assign free_raddr = free_top_dec[HW-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (cmd_reg)
                    CMD_INSERT: begin
                        if (live_count_reg != '0 && !in_range) begin
                            state_next = S_RESP;
                        end else if (free_top_reg != '0) begin
                            state_next = S_ALLOC;
                        end else if (fresh_next_reg < NIL) begin
                            state_next = S_LINK_RD;
                        end else begin
                            state_next = S_RESP;
                        end
                    end
                    CMD_PEEK, CMD_DEL_MIN: begin
                        state_next = (live_count_reg == '0) ? S_RESP : S_HEAD;
                    end
                    CMD_REMOVE, CMD_REKEY: begin
                        state_next = handle_known ? S_LIVE : S_RESP;
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_ALLOC:   state_next = S_LINK_RD;
            S_LINK_RD: state_next = S_LINK_WR;
            S_LINK_WR: begin
                if (bkt_first != NIL) begin
                    state_next = S_LINK_FIX;
                end else begin
                    state_next = (cmd_reg == CMD_INSERT) ? S_RESP : S_RESCAN;
                end
            end
            S_LINK_FIX: state_next = (cmd_reg == CMD_INSERT) ? S_RESP : S_RESCAN;
            S_HEAD:     state_next = S_INFO;
            S_INFO:     state_next = (cmd_reg == CMD_DEL_MIN) ? S_UNL_RD : S_RESP;
            S_LIVE: begin
                if (!live_rdata) begin
                    state_next = S_RESP;
                end else if (cmd_reg == CMD_REKEY && !in_range) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_UNL_RD;
                end
            end
            S_UNL_RD: state_next = S_UNL_WR;
            S_UNL_WR: state_next = is_del ? S_RESCAN : S_LINK_RD;
            S_RESCAN: begin
                if (live_count_reg == '0 || bnz_reg[min_bucket_reg]) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // RAM write controls
    always_comb begin
        head_we = 1'b0; head_waddr = nb_reg;          head_wdata = LW'(h_reg);
        next_we = 1'b0; next_waddr = h_reg;           next_wdata = bkt_first;
        prev_we = 1'b0; prev_waddr = h_reg;           prev_wdata = NIL;
        bkt_we  = 1'b0; bkt_waddr  = h_reg;           bkt_wdata  = nb_reg;
        info_we = 1'b0; info_waddr = h_reg;           info_wdata = pay_reg;
        live_we = 1'b0; live_waddr = h_reg;           live_wdata = 1'b1;
        free_we = 1'b0; free_waddr = free_top_reg[HW-1:0]; free_wdata = h_reg;
        unique case (state_reg)
            S_LINK_WR: begin
                head_we = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
                bkt_we  = 1'b1;
                info_we = (cmd_reg == CMD_INSERT);
                live_we = (cmd_reg == CMD_INSERT);
            end
            S_LINK_FIX: begin
                prev_we    = 1'b1;
                prev_waddr = n_reg[HW-1:0];
                prev_wdata = LW'(h_reg);
            end
            S_UNL_WR: begin
                if (prev_rdata == NIL) begin
                    head_we    = 1'b1;
                    head_waddr = bkt_rdata;
                    head_wdata = next_rdata;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata[HW-1:0];
                    next_wdata = next_rdata;
                end
                if (next_rdata != NIL) begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata[HW-1:0];
                    prev_wdata = prev_rdata;
                end
                live_we    = is_del;
                live_wdata = 1'b0;
                free_we    = is_del && (free_top_reg < NIL);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            bnz_reg        <= '0;
            free_top_reg   <= '0;
            fresh_next_reg <= '0;
            min_bucket_reg <= '0;
            min_value_reg  <= '0;
            live_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    cmd_reg <= s_cmd;
                    key_reg <= s_key;
                    pay_reg <= s_payload;
                    hin_reg <= s_handle;
                end
                S_DECODE: begin
                    res_handle_reg <= '0;
                    res_pay_reg    <= '0;
                    unique case (cmd_reg)
                        CMD_INSERT: begin
                            if (live_count_reg != '0 && !in_range) begin
                                res_status_reg <= ST_KEY_RANGE;
                            end else if (free_top_reg == '0 && fresh_next_reg >= NIL) begin
                                res_status_reg <= ST_NO_FREE;
                            end else begin
                                res_status_reg <= ST_OK;
                                if (free_top_reg != '0) begin
                                    free_top_reg <= free_top_dec;
                                end else begin
                                    h_reg          <= fresh_next_reg[HW-1:0];
                                    fresh_next_reg <= fresh_next_reg + LW'(1);
                                end
                                // The first item of an empty queue fixes the minimum.
                                if (live_count_reg == '0) begin
                                    nb_reg         <= '0;
                                    min_bucket_reg <= '0;
                                    min_value_reg  <= key_reg;
                                end else begin
                                    nb_reg <= new_bkt;
                                end
                            end
                        end
                        CMD_PEEK, CMD_DEL_MIN: begin
                            res_status_reg <= (live_count_reg == '0) ? ST_EMPTY : ST_OK;
                        end
                        CMD_REMOVE, CMD_REKEY: begin
                            res_status_reg <= handle_known ? ST_OK : ST_BAD_HANDLE;
                            h_reg          <= HW'(hin_reg);
                        end
                        CMD_CLEAR: begin
                            res_status_reg <= ST_OK;
                            bnz_reg        <= '0;
                            free_top_reg   <= '0;
                            fresh_next_reg <= '0;
                            min_bucket_reg <= '0;
                            min_value_reg  <= '0;
                            live_count_reg <= '0;
                        end
                        default: res_status_reg <= ST_OK;
                    endcase
                end
                S_ALLOC: h_reg <= free_rdata;
                S_LINK_WR: begin
                    bnz_reg[nb_reg] <= 1'b1;
                    n_reg           <= bkt_first;
                    if (cmd_reg == CMD_INSERT) begin
                        live_count_reg <= live_count_reg + LW'(1);
                        res_handle_reg <= h_reg;
                    end
                end
                S_HEAD: h_reg <= head_rdata[HW-1:0];
                S_INFO: begin
                    res_handle_reg <= h_reg;
                    res_pay_reg    <= info_rdata;
                end
                S_LIVE: begin
                    if (!live_rdata) begin
                        res_status_reg <= ST_BAD_HANDLE;
                    end else if (cmd_reg == CMD_REKEY) begin
                        if (!in_range) begin
                            res_status_reg <= ST_KEY_RANGE;
                        end
                        nb_reg <= new_bkt;
                    end
                end
                S_UNL_WR: begin
                    if (prev_rdata == NIL) begin
                        bnz_reg[bkt_rdata] <= (next_rdata != NIL);
                    end
                    if (is_del) begin
                        live_count_reg <= live_count_reg - LW'(1);
                        if (free_top_reg < NIL) begin
                            free_top_reg <= free_top_reg + LW'(1);
                        end
                    end
                end
                S_RESCAN: begin
                    // Step past empty buckets; each one raises the minimum key by one.
                    if (live_count_reg != '0 && !bnz_reg[min_bucket_reg]) begin
                        min_bucket_reg <= (min_bucket_reg == BW'(BUCKETS - 1))
                                          ? '0 : min_bucket_reg + BW'(1);
                        min_value_reg  <= min_value_reg + KEY_W'(1);
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        m_status_reg <= res_status_reg;
                        m_handle_reg <= HANDLE_W'(res_handle_reg);
                        m_pay_reg    <= res_pay_reg;
                        m_count_reg  <= COUNT_W'(live_count_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_item_handle  = m_handle_reg;
    assign m_item_payload = m_pay_reg;
    assign m_item_count   = m_count_reg;

    cbpq_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    cbpq_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(h_reg), .rdata(next_rdata)
    );
    cbpq_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
        .aclk(aclk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(h_reg), .rdata(prev_rdata)
    );
    cbpq_ram #(.WIDTH(BW), .DEPTH(CAPACITY)) u_bkt_ram (
        .aclk(aclk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .raddr(h_reg), .rdata(bkt_rdata)
    );
    cbpq_ram #(.WIDTH(PAY_W), .DEPTH(CAPACITY)) u_info_ram (
        .aclk(aclk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_rdata)
    );
    cbpq_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_live_ram (
        .aclk(aclk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
        .raddr(live_raddr), .rdata(live_rdata)
    );
    cbpq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_free_ram (
        .aclk(aclk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .raddr(free_raddr), .rdata(free_rdata)
    );

    // Every issued handle is either held in the queue or waiting on the free stack.
    a_handle_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> live_count_reg + free_top_reg == fresh_next_reg)
        else $error("handle accounting out of balance");

    // A non-empty queue always has an occupied bucket for the scan to stop at.
    a_scan_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESCAN && live_count_reg != '0) |-> (bnz_reg != '0))
        else $error("scan running with no occupied bucket");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_count_reg <= NIL)
        else $error("item count above capacity");

    // Once settled, the minimum bucket of a non-empty queue is occupied.
    a_min_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && live_count_reg != '0) |-> bnz_reg[min_bucket_reg])
        else $error("minimum bucket empty while queue holds items");

endmodule
